@@ design/sparse_disk_table_cache_lfu_assert.svh @@
// assertion macros for the sparse disk table cache
// no dependencies; included by the modules that carry assertions
`ifndef SPARSE_DISK_TABLE_CACHE_LFU_ASSERT_SVH
`define SPARSE_DISK_TABLE_CACHE_LFU_ASSERT_SVH

// same-cycle implication
`define SDTC_ASSERT_IMP(name, clk_s, rstn_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDTC_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sdtc_pkg.sv @@
// types and constants shared by the sparse disk table cache
// no dependencies
`default_nettype none

package sdtc_pkg;

    localparam int PADDR_W     = 4;
    localparam int ADDR_MAX_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [31:0] COUNT_TOP = 32'hffff_ffff;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    localparam logic [1:0] ST_UNMAPPED = 2'd0;
    localparam logic [1:0] ST_HIT      = 2'd1;
    localparam logic [1:0] ST_MISS     = 2'd2;
    localparam logic [1:0] ST_LOAD     = 2'd3;

    localparam logic [1:0] REG_DIR_ENTRIES   = 2'd0;
    localparam logic [1:0] REG_CLUSTER_SHIFT = 2'd1;
    localparam logic [1:0] REG_TABLE_SHIFT   = 2'd2;

    localparam logic [12:0] DIR_ENTRIES_RST   = 13'd0;
    localparam logic [4:0]  CLUSTER_SHIFT_RST = 5'd7;
    localparam logic [3:0]  TABLE_SHIFT_RST   = 4'd9;

    typedef struct packed {
        logic        req_type;
        logic [31:0] sector;
        logic [11:0] load_index;
        logic [31:0] load_value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  way;
        logic [31:0] table_sector;
        logic [11:0] entry_index;
        logic [11:0] dir_index;
    } res_t;

    typedef struct packed {
        logic [12:0] dir_entries;
        logic [4:0]  cluster_shift;
        logic [3:0]  table_shift;
    } cfg_t;

    typedef enum logic [1:0] {
        JOB_LOAD,
        JOB_UNMAPPED,
        JOB_LOOKUP
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic                  load_wr;
        logic [ADDR_MAX_W-1:0] addr;
        logic [31:0]           data;
        logic [11:0]           entry_index;
        logic [11:0]           dir_index;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MATCH,
        B_HIT,
        B_SCAN,
        B_FILL,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

@@ design/sdtc_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module sdtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/sdtc_front.sv @@
// front end: accepts requests, splits the sector and classifies each request
// depends on sdtc_pkg
`default_nettype none

module sdtc_front #(
    parameter int DIR_DEPTH = 4096
) (
    input  wire logic           item_valid,
    input  wire sdtc_pkg::req_t item,
    input  wire sdtc_pkg::cfg_t cfg,
    input  wire logic           q_full,
    output logic                item_stall,
    output logic                push,
    output sdtc_pkg::job_t      job
);

    localparam logic [31:0] DEPTH32 = 32'(DIR_DEPTH);

    logic [5:0]  shift_sum;
    logic [31:0] didx;
    logic [31:0] eshift;
    logic [15:0] emask;
    logic [11:0] eidx;
    logic        in_range;
    logic        load_ok;

    always_comb
    begin
        shift_sum = {1'b0, cfg.cluster_shift} + {2'b00, cfg.table_shift};
        didx      = item.sector >> shift_sum;
        eshift    = item.sector >> cfg.cluster_shift;
        emask     = ~(16'hffff << cfg.table_shift);
        eidx      = eshift[11:0] & emask[11:0];
        in_range  = (didx < {19'd0, cfg.dir_entries}) && (didx < DEPTH32);
        load_ok   = ({20'd0, item.load_index} < DEPTH32);

        if (item.req_type == sdtc_pkg::REQ_LOAD)
        begin
            job.kind        = sdtc_pkg::JOB_LOAD;
            job.load_wr     = load_ok;
            job.addr        = sdtc_pkg::ADDR_MAX_W'(item.load_index);
            job.data        = item.load_value;
            job.entry_index = 12'd0;
            job.dir_index   = item.load_index;
        end
        else
        begin
            job.kind        = in_range ? sdtc_pkg::JOB_LOOKUP : sdtc_pkg::JOB_UNMAPPED;
            job.load_wr     = 1'b0;
            job.addr        = didx[sdtc_pkg::ADDR_MAX_W-1:0];
            job.data        = 32'd0;
            job.entry_index = eidx;
            job.dir_index   = didx[11:0];
        end
    end

    assign item_stall = q_full;
    assign push       = item_valid && !q_full;

endmodule

`default_nettype wire

@@ design/sdtc_queue.sv @@
// short request queue between front and back end
// depends on sdtc_pkg
`default_nettype none

module sdtc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire sdtc_pkg::job_t wdata,
    input  wire logic           pop,
    output sdtc_pkg::job_t      head,
    output logic                full,
    output logic                empty
);

    sdtc_pkg::job_t                    slot_reg [sdtc_pkg::QUEUE_DEPTH];
    logic [sdtc_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [sdtc_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [sdtc_pkg::QCNT_W-1:0]       count_reg;
    logic [sdtc_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [sdtc_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [sdtc_pkg::QCNT_W-1:0]       count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == sdtc_pkg::QCNT_W'(sdtc_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);

endmodule

`default_nettype wire

@@ design/sdtc_back.sv @@
// back end: directory memory, way tags, lfu counts and the result register
// depends on sdtc_pkg, sdtc_ram and the assertion macro header
`default_nettype none
`include "sparse_disk_table_cache_lfu_assert.svh"

module sdtc_back #(
    parameter int WAYS      = 16,
    parameter int DIR_DEPTH = 4096
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sdtc_pkg::job_t head,
    input  wire logic           q_empty,
    output logic                pop,
    output logic                result_valid,
    input  wire logic           result_stall,
    output sdtc_pkg::res_t      result
);

    localparam int WW = $clog2(WAYS);
    localparam int AW = $clog2(DIR_DEPTH);
    localparam logic [WW-1:0] LAST_WAY = WW'(WAYS - 1);

    sdtc_pkg::back_state_t state_reg, state_next;
    sdtc_pkg::job_t        job_reg, job_next;
    sdtc_pkg::res_t        res_reg, res_next;
    sdtc_pkg::res_t        out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           entry_reg, entry_next;
    logic [WW-1:0]         hit_reg, hit_next;
    logic [WW-1:0]         scan_reg, scan_next;
    logic [WW-1:0]         victim_reg, victim_next;
    logic [31:0]           vcount_reg, vcount_next;
    logic [31:0]           tag_reg [WAYS];
    logic [31:0]           tag_next [WAYS];
    logic [31:0]           count_reg [WAYS];
    logic [31:0]           count_next [WAYS];

    logic          ram_we;
    logic          ram_re;
    logic [31:0]   ram_rdata;
    logic [WW-1:0] rd_idx;
    logic [31:0]   cnt_sel;
    logic [31:0]   cnt_inc;
    logic          hit_any;
    logic [WW-1:0] hit_idx;

    sdtc_ram #(
        .WIDTH (32),
        .DEPTH (DIR_DEPTH)
    ) u_dir_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head.addr[AW-1:0]),
        .wdata (head.data),
        .re    (ram_re),
        .raddr (head.addr[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        rd_idx  = (state_reg == sdtc_pkg::B_SCAN) ? scan_reg : hit_reg;
        cnt_sel = count_reg[rd_idx];
        cnt_inc = cnt_sel + 32'd1;
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (tag_reg[i] == ram_rdata)
            begin
                hit_any = 1'b1;
                hit_idx = WW'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        entry_next     = entry_reg;
        hit_next       = hit_reg;
        scan_next      = scan_reg;
        victim_next    = victim_reg;
        vcount_next    = vcount_reg;
        tag_next       = tag_reg;
        count_next     = count_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sdtc_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    job_next = head;
                    case (head.kind)
                        sdtc_pkg::JOB_LOAD:
                        begin
                            ram_we     = head.load_wr;
                            res_next   = '{sdtc_pkg::ST_LOAD, 4'd0, head.data,
                                           12'd0, head.dir_index};
                            state_next = sdtc_pkg::B_DONE;
                        end
                        sdtc_pkg::JOB_LOOKUP:
                        begin
                            ram_re     = 1'b1;
                            state_next = sdtc_pkg::B_MATCH;
                        end
                        default:
                        begin
                            res_next   = '{sdtc_pkg::ST_UNMAPPED, 4'd0, 32'd0,
                                           head.entry_index, head.dir_index};
                            state_next = sdtc_pkg::B_DONE;
                        end
                    endcase
                end
            end
            sdtc_pkg::B_MATCH:
            begin
                entry_next = ram_rdata;
                if (ram_rdata == 32'd0)
                begin
                    res_next   = '{sdtc_pkg::ST_UNMAPPED, 4'd0, 32'd0,
                                   job_reg.entry_index, job_reg.dir_index};
                    state_next = sdtc_pkg::B_DONE;
                end
                else if (hit_any)
                begin
                    hit_next   = hit_idx;
                    state_next = sdtc_pkg::B_HIT;
                end
                else
                begin
                    scan_next   = '0;
                    victim_next = '0;
                    vcount_next = sdtc_pkg::COUNT_TOP;
                    state_next  = sdtc_pkg::B_SCAN;
                end
            end
            sdtc_pkg::B_HIT:
            begin
                if (cnt_inc == sdtc_pkg::COUNT_TOP)
                begin
                    for (int j = 0; j < WAYS; j++)
                    begin
                        count_next[j] = count_reg[j] >> 1;
                    end
                end
                else
                begin
                    count_next[hit_reg] = cnt_inc;
                end
                res_next   = '{sdtc_pkg::ST_HIT, 4'(hit_reg), entry_reg,
                               job_reg.entry_index, job_reg.dir_index};
                state_next = sdtc_pkg::B_DONE;
            end
            sdtc_pkg::B_SCAN:
            begin
                if (cnt_sel < vcount_reg)
                begin
                    vcount_next = cnt_sel;
                    victim_next = scan_reg;
                end
                if (scan_reg == LAST_WAY)
                begin
                    state_next = sdtc_pkg::B_FILL;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            sdtc_pkg::B_FILL:
            begin
                tag_next[victim_reg]   = entry_reg;
                count_next[victim_reg] = 32'd1;
                res_next   = '{sdtc_pkg::ST_MISS, 4'(victim_reg), entry_reg,
                               job_reg.entry_index, job_reg.dir_index};
                state_next = sdtc_pkg::B_DONE;
            end
            sdtc_pkg::B_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = sdtc_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = sdtc_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdtc_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < WAYS; k++)
            begin
                tag_reg[k]   <= 32'd0;
                count_reg[k] <= 32'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            tag_reg       <= tag_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
        entry_reg  <= entry_next;
        hit_reg    <= hit_next;
        scan_reg   <= scan_next;
        victim_reg <= victim_next;
        vcount_reg <= vcount_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `SDTC_ASSERT_IMP(a_pop_idle, clk, rst_n, pop,
        (state_reg == sdtc_pkg::B_IDLE) && !q_empty,
        "request taken from queue while back end busy")
    `SDTC_ASSERT_NEXT(a_fill_way, clk, rst_n, state_reg == sdtc_pkg::B_FILL,
        (count_reg[victim_reg] == 32'd1) && (tag_reg[victim_reg] == entry_reg),
        "victim way not retagged")
    `SDTC_ASSERT_NEXT(a_done_hold, clk, rst_n,
        (state_reg == sdtc_pkg::B_DONE) && out_valid_reg && result_stall,
        state_reg == sdtc_pkg::B_DONE, "result dropped while output stalled")
    `SDTC_ASSERT_NEXT(a_scan_step, clk, rst_n,
        (state_reg == sdtc_pkg::B_SCAN) && (scan_reg != LAST_WAY),
        (state_reg == sdtc_pkg::B_SCAN) && (scan_reg == $past(scan_reg) + 1'b1),
        "victim scan skipped a way")

endmodule

`default_nettype wire

@@ design/sparse_disk_table_cache_lfu.sv @@
// top level of the sparse disk table cache with lfu way replacement
// depends on sdtc_pkg, sdtc_front, sdtc_queue, sdtc_back
//
//   channel   handshake              payload
//   item      item_valid/item_stall  item   (req_type, sector, load_index, load_value)
//   result    result_valid/stall     result (status, way, table_sector, entry/dir index)
//   apb       psel/penable/pready    paddr, pwdata, prdata
//
// a request enters a four-deep queue at acceptance, the back end takes it once idle
// load or out-of-range lookup: straight to the result; else one directory ram read,
// then zero entry: done; hit: count update; miss: scan one way per cycle, then fill
// reset sets config defaults, clears queue, tags, counts; directory ram is not cleared
// item_stall is high while the queue is full; a stalled result holds the back end
`default_nettype none

module sparse_disk_table_cache_lfu #(
    parameter int WAYS      = 16,
    parameter int DIR_DEPTH = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire sdtc_pkg::req_t                item,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output sdtc_pkg::res_t                     result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sdtc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    sdtc_pkg::cfg_t cfg_reg;
    sdtc_pkg::job_t front_job;
    sdtc_pkg::job_t q_head;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dir_entries   <= sdtc_pkg::DIR_ENTRIES_RST;
            cfg_reg.cluster_shift <= sdtc_pkg::CLUSTER_SHIFT_RST;
            cfg_reg.table_shift   <= sdtc_pkg::TABLE_SHIFT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                sdtc_pkg::REG_DIR_ENTRIES:   cfg_reg.dir_entries   <= pwdata[12:0];
                sdtc_pkg::REG_CLUSTER_SHIFT: cfg_reg.cluster_shift <= pwdata[4:0];
                sdtc_pkg::REG_TABLE_SHIFT:   cfg_reg.table_shift   <= pwdata[3:0];
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            sdtc_pkg::REG_DIR_ENTRIES:   prdata = 32'(cfg_reg.dir_entries);
            sdtc_pkg::REG_CLUSTER_SHIFT: prdata = 32'(cfg_reg.cluster_shift);
            sdtc_pkg::REG_TABLE_SHIFT:   prdata = 32'(cfg_reg.table_shift);
            default:                     prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    sdtc_front #(
        .DIR_DEPTH (DIR_DEPTH)
    ) u_front (
        .item_valid (item_valid),
        .item       (item),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .item_stall (item_stall),
        .push       (push),
        .job        (front_job)
    );

    sdtc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_job),
        .pop   (pop),
        .head  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    sdtc_back #(
        .WAYS      (WAYS),
        .DIR_DEPTH (DIR_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_empty      (q_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
